// File: hw/rtl/nmea_gga_time_position_parser_assert.svh
// Assertion macros for the GGA parser RTL.
// Concurrent checks are clocked on clk_i; the plain form is disabled while rst_ni is low.
`ifndef NMEA_GGA_TIME_POSITION_PARSER_ASSERT_SVH
`define NMEA_GGA_TIME_POSITION_PARSER_ASSERT_SVH
`ifndef SYNTH
`define NGGP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nggp assertion failed");
`define NGGP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("nggp assertion failed");
`else
`define NGGP_ASSERT(lbl, prop)
`define NGGP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hw/rtl/nggp_pkg.sv
// Shared types, character codes and helper functions of the GGA parser.
// No dependencies; used by every module of the block.
package nggp_pkg;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [3:0] TIME_CHARS = 4'd6;
  localparam logic [3:0] COUNT_MAX  = 4'd15;
  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_W       = 32;
  localparam int POW_W       = 20;
  localparam int HMS_W       = 7;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DIGIT,
    CLS_POINT,
    CLS_COMMA,
    CLS_DOLLAR
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
    logic       last;
  } op_t;

  typedef struct packed {
    logic             err;
    logic [NUM_W-1:0] lon;
    logic [NUM_W-1:0] lat;
    logic [HMS_W-1:0] second;
    logic [HMS_W-1:0] minute;
    logic [HMS_W-1:0] hour;
  } res_t;

  // Powers of ten for the fraction scaling, up to six digits.
  function automatic logic [POW_W-1:0] pow10(input logic [2:0] k);
    logic [POW_W-1:0] p;
    case (k)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/nggp_front.sv
// Front end of the GGA parser: takes character transfers and classifies them.
// Depends on nggp_pkg; feeds nggp_queue.
module nggp_front (
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic [7:0]    char_i,
  input  logic          last_i,
  input  logic          q_full_i,
  output logic          push_o,
  output nggp_pkg::op_t op_o
);
  import nggp_pkg::*;

  logic [7:0] diff;

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;
  assign diff      = char_i - CH_ZERO;

  always_comb begin
    op_o.last  = last_i;
    op_o.digit = diff[3:0];
    if (char_i inside {[CH_ZERO:CH_NINE]}) begin
      op_o.cls = CLS_DIGIT;
    end else if (char_i == CH_POINT) begin
      op_o.cls = CLS_POINT;
    end else if (char_i == CH_COMMA) begin
      op_o.cls = CLS_COMMA;
    end else if (char_i == CH_DOLLAR) begin
      op_o.cls = CLS_DOLLAR;
    end else begin
      op_o.cls = CLS_OTHER;
    end
  end

endmodule

// File: hw/rtl/nggp_queue.sv
// Short queue of classified characters between front and back end.
// Depends on nggp_pkg for the entry type and depth.
module nggp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nggp_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output nggp_pkg::op_t op_o
);
  import nggp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  op_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DEPTH_C);
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// File: hw/rtl/nggp_back.sv
// Back end of the GGA parser: sentence state, field accumulators and result register.
// Depends on nggp_pkg and the assertion macro header.
`include "nmea_gga_time_position_parser_assert.svh"

module nggp_back #(
  parameter int FRAC_DIGITS = 4,
  parameter int FIELD_CHARS = 9
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  nggp_pkg::op_t  op_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output nggp_pkg::res_t res_o
);
  import nggp_pkg::*;

  localparam logic [2:0] FRAC_LIM = 3'(FRAC_DIGITS);
  localparam logic [3:0] FLD_LIM  = 4'(FIELD_CHARS);

  logic             first_q, first_d, valid_q, valid_d;
  logic [3:0]       cc_q, cc_d, fcc_q, fcc_d;
  logic [NUM_W-1:0] acc_q, acc_d, lat_q, lat_d, lon_q, lon_d;
  logic             pt_q, pt_d, bad_q, bad_d;
  logic [2:0]       frac_q, frac_d;
  logic [3:0]       dig_q [6];
  logic [3:0]       dig_d [6];
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic             go, emit, sentence_now, out_free, is_comma;
  logic [NUM_W+3:0] acc10;
  logic [NUM_W-1:0] acc_next;
  logic [NUM_W-1:0] num_acc;
  logic [2:0]       num_frac;
  logic             num_pt;
  logic [3:0]       num_fcc;
  logic [NUM_W-1:0] fin_acc, fin, fin_end;
  logic [2:0]       fin_frac;
  logic [NUM_W+POW_W-1:0] prod;
  logic [HMS_W-1:0] hh, mm, ss;
  logic             err;

  assign is_comma     = (op_i.cls == CLS_COMMA);
  assign sentence_now = first_q ? (op_i.cls == CLS_DOLLAR) : valid_q;
  assign emit         = op_i.last && sentence_now;
  assign out_free     = !out_valid_q || m_ready_i;
  assign go           = q_valid_i && (!emit || out_free);
  assign pop_o        = go;

  // Decimal shift-in of one digit, saturating at the word limit.
  assign acc10    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (NUM_W+4)'(op_i.digit);
  assign acc_next = (acc10[NUM_W+3:NUM_W] != '0) ? '1 : acc10[NUM_W-1:0];

  // Number field state after this character, when the open field is a position field.
  always_comb begin
    num_acc  = acc_q;
    num_frac = frac_q;
    num_pt   = pt_q;
    num_fcc  = fcc_q;
    if (fcc_q < FLD_LIM) begin
      if (op_i.cls == CLS_DIGIT) begin
        if (!pt_q || frac_q < FRAC_LIM) begin
          num_acc = acc_next;
          if (pt_q) begin
            num_frac = frac_q + 1'b1;
          end
        end
        num_fcc = fcc_q + 1'b1;
      end else if (op_i.cls == CLS_POINT && !pt_q) begin
        num_pt  = 1'b1;
        num_fcc = fcc_q + 1'b1;
      end else begin
        num_fcc = COUNT_MAX;
      end
    end
  end

  // Closing scale: at a comma the field being closed is the stored one, otherwise it is the
  // field after this character. A comma that is also the last character closes an empty field.
  assign fin_acc  = is_comma ? acc_q  : num_acc;
  assign fin_frac = is_comma ? frac_q : num_frac;
  assign prod     = fin_acc * pow10(FRAC_LIM - fin_frac);
  assign fin      = (prod[NUM_W+POW_W-1:NUM_W] != '0) ? '1 : prod[NUM_W-1:0];
  assign fin_end  = is_comma ? '0 : fin;

  always_comb begin
    first_d = first_q;
    valid_d = valid_q;
    cc_d    = cc_q;
    fcc_d   = fcc_q;
    acc_d   = acc_q;
    pt_d    = pt_q;
    frac_d  = frac_q;
    bad_d   = bad_q;
    lat_d   = lat_q;
    lon_d   = lon_q;
    dig_d   = dig_q;
    if (go) begin
      if (first_q) begin
        first_d = 1'b0;
        valid_d = (op_i.cls == CLS_DOLLAR);
        if (op_i.cls == CLS_DOLLAR) begin
          lat_d = '0;
          lon_d = '0;
        end
      end else if (valid_q) begin
        if (is_comma) begin
          if (cc_q == 4'd1 && fcc_q < TIME_CHARS) begin
            bad_d = 1'b1;
          end else if (cc_q == 4'd2) begin
            lat_d = fin;
          end else if (cc_q == 4'd4) begin
            lon_d = fin;
          end
          if (cc_q != COUNT_MAX) begin
            cc_d = cc_q + 1'b1;
          end
          fcc_d  = '0;
          acc_d  = '0;
          pt_d   = 1'b0;
          frac_d = '0;
        end else if (cc_q == 4'd1) begin
          if (fcc_q < TIME_CHARS) begin
            if (op_i.cls == CLS_DIGIT) begin
              dig_d[fcc_q[2:0]] = op_i.digit;
            end else begin
              bad_d = 1'b1;
            end
          end
          if (fcc_q != COUNT_MAX) begin
            fcc_d = fcc_q + 1'b1;
          end
        end else if (cc_q == 4'd2 || cc_q == 4'd4) begin
          acc_d  = num_acc;
          frac_d = num_frac;
          pt_d   = num_pt;
          fcc_d  = num_fcc;
        end
      end
      // End of sentence: close the open field, then the per-sentence state starts over.
      if (op_i.last) begin
        if (sentence_now) begin
          if (cc_d == 4'd1 && fcc_d < TIME_CHARS) begin
            bad_d = 1'b1;
          end else if (cc_d == 4'd2) begin
            lat_d = fin_end;
          end else if (cc_d == 4'd4) begin
            lon_d = fin_end;
          end
        end
      end
    end
  end

  assign err = bad_d || (cc_d == '0);
  assign hh  = ({3'b0, dig_d[0]} << 3) + ({3'b0, dig_d[0]} << 1) + {3'b0, dig_d[1]};
  assign mm  = ({3'b0, dig_d[2]} << 3) + ({3'b0, dig_d[2]} << 1) + {3'b0, dig_d[3]};
  assign ss  = ({3'b0, dig_d[4]} << 3) + ({3'b0, dig_d[4]} << 1) + {3'b0, dig_d[5]};

  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (go && emit) begin
      out_valid_d  = 1'b1;
      res_d.err    = err;
      res_d.hour   = err ? '0 : hh;
      res_d.minute = err ? '0 : mm;
      res_d.second = err ? '0 : ss;
      res_d.lat    = lat_d;
      res_d.lon    = lon_d;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_valid_o = out_valid_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      valid_q     <= 1'b0;
      cc_q        <= '0;
      fcc_q       <= '0;
      acc_q       <= '0;
      pt_q        <= 1'b0;
      frac_q      <= '0;
      bad_q       <= 1'b0;
      lat_q       <= '0;
      lon_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      lat_q       <= lat_d;
      lon_q       <= lon_d;
      if (go && op_i.last) begin
        first_q <= 1'b1;
        valid_q <= 1'b0;
        cc_q    <= '0;
        fcc_q   <= '0;
        acc_q   <= '0;
        pt_q    <= 1'b0;
        frac_q  <= '0;
        bad_q   <= 1'b0;
      end else begin
        first_q <= first_d;
        valid_q <= valid_d;
        cc_q    <= cc_d;
        fcc_q   <= fcc_d;
        acc_q   <= acc_d;
        pt_q    <= pt_d;
        frac_q  <= frac_d;
        bad_q   <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    res_q <= res_d;
  end

  `NGGP_ASSERT(a_last_rearms, (go && op_i.last) |=> first_q)
  `NGGP_ASSERT(a_dollar_clears_kept,
    (go && first_q && op_i.cls == CLS_DOLLAR) |=> (lat_q == '0 && lon_q == '0))
  `NGGP_ASSERT_ALWAYS(a_idle_no_commas, !valid_q |-> (cc_q == '0))

endmodule

// File: hw/rtl/nmea_gga_time_position_parser.sv
// Top level of the NMEA GGA time and position parser.
// Depends on nggp_pkg, nggp_front, nggp_queue and nggp_back.
//
// The parser takes one sentence character per transfer on the slave stream, with tlast on
// the last character of a sentence. A sentence is parsed only when its first character is
// '$'. Commas split it into fields: the first six characters after comma one are the UTC
// time digits, the field after comma two is the latitude and the field after comma four is
// the longitude, each read as an unsigned decimal number with an optional point and scaled
// by 10^FRAC_DIGITS (extra fraction digits are truncated, values saturate at the 32-bit
// maximum, only the first FIELD_CHARS characters of a field count, and a stray character
// ends the number). At the last character of a valid sentence one transfer leaves on the
// master stream with the time, both positions and a time-format flag in tuser; when that
// flag is set the time fields read zero. Invalid sentences produce nothing. The block
// sustains one character per clock cycle: a combinational classifier feeds a two-entry
// queue, and the back end retires one queued character per cycle with its running
// accumulators. A result goes through the queue and the output register before it becomes
// valid on the master side. Only a character that closes a sentence waits on the output
// register, so a stalled master side holds up the input only once the queue has filled.
module nmea_gga_time_position_parser #(
  parameter int FRAC_DIGITS = 4,
  parameter int FIELD_CHARS = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] char_in
  input  logic        s_axis_tlast_i,  // end_of_sentence
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [6:0] hour_out, [13:7] minute_out, [20:14] second_out, [52:21] latitude_fixed,
  // [84:53] longitude_fixed, [87:85] zero
  output logic [87:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o   // [0] time_format_error
);
  import nggp_pkg::*;

  op_t  push_op, pop_op;
  logic push, q_full, q_valid, pop;
  res_t res;

  // Classification of each incoming character.
  nggp_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .char_i    (s_axis_tdata_i),
    .last_i    (s_axis_tlast_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .op_o      (push_op)
  );

  // Decoupling queue between classifier and parser state.
  nggp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (pop_op)
  );

  // Sentence parsing and the result register.
  nggp_back #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .FIELD_CHARS (FIELD_CHARS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .op_i      (pop_op),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .res_o     (res)
  );

  assign m_axis_tdata_o = {3'b000, res.lon, res.lat, res.second, res.minute, res.hour};
  assign m_axis_tuser_o = res.err;

endmodule
